/* hdl/normalized_l2_distance_matcher_defines.svh */
// assertion macros shared by the distance matcher rtl
`ifndef NORMALIZED_L2_DISTANCE_MATCHER_DEFINES_SVH
`define NORMALIZED_L2_DISTANCE_MATCHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// expression holds at every edge out of reset
`define NLDM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// condition at one edge implies the expression at the next edge
`define NLDM_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error(msg);

// condition implies the expression at the same edge
`define NLDM_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error(msg);

`else

`define NLDM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define NLDM_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`define NLDM_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg)

`endif

`endif

/* hdl/nldm_pkg.sv */
// types and constants of the normalized distance matcher
package nldm_pkg;

    localparam int BYTE_W  = 8;
    localparam int DIST_W  = 17;
    localparam int THR_W   = 17;
    localparam int DIGIT_W = 4;
    localparam int Q_W     = 34;
    localparam int Q2_W    = 67;
    localparam int SHIFT_W = 64;
    localparam int BIT_W   = 5;

    localparam logic [DIST_W-1:0] MAX_DIST = 17'd92681;
    localparam logic [DIST_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [Q_W-1:0]    TWO_Q32  = 34'h2_0000_0000;
    localparam logic [BIT_W-1:0]  TOP_BIT  = 5'd16;

    typedef enum logic [3:0] {
        S_ACC,
        S_START,
        S_MUL_LR,
        S_MUL_DD,
        S_TRY,
        S_MUL_D,
        S_MUL_Q,
        S_MUL_P,
        S_NEXT,
        S_OUT
    } t_state;

endpackage

/* hdl/normalized_l2_distance_matcher.sv */
// normalized euclidean distance between two byte fingerprints
//
// Input channel (i_in_valid / o_in_stall) takes one byte pair per beat,
// i_last marks the final pair. Pairs are summed in the cycle they arrive,
// so a fingerprint streams in at one beat per cycle. Pairs past
// MAX_LENGTH are ignored, but a last mark on them still closes the vector.
// After the last beat the block stalls its input and runs a bitwise search
// for the 17-bit distance: each trial squares the candidate, squares
// 2^33 - d^2 and scales that by |L|^2*|R|^2 on one shared multiplier that
// takes 4 bits of the multiplier operand per cycle. After two setup
// products, up to 17 trials run before the result moves to the output;
// a vector with an all-zero side skips the search. The input stays
// stalled until the result has been handed to the output register.
// The result sits in an output register (o_out_valid / i_out_stall); the
// next fingerprint may stream in while it waits, and a new result waits
// in the sequencer until the register is free.
// The threshold is written on i_cfg_valid / o_cfg_ready, always ready.
// Reset clears the sums, pair count, threshold and any pending result.
`include "normalized_l2_distance_matcher_defines.svh"

module normalized_l2_distance_matcher
    import nldm_pkg::*;
#(
    parameter int MAX_LENGTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte pair channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_left_byte,
    input  logic [BYTE_W-1:0] i_right_byte,
    input  logic              i_last,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DIST_W-1:0] o_distance,
    output logic              o_within_threshold,
    // threshold write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [THR_W-1:0]  i_cfg_match_threshold
);

    localparam int SUM_W = $clog2(MAX_LENGTH * 65025 + 1);
    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int P_W   = 2 * SUM_W;
    localparam int MW    = (P_W > Q_W) ? P_W : Q_W;
    localparam int CW    = P_W + Q2_W;

    // control state
    t_state             r_state, n_state;
    logic [SUM_W-1:0]   r_left_sum, n_left_sum;
    logic [SUM_W-1:0]   r_right_sum, n_right_sum;
    logic [SUM_W-1:0]   r_cross_sum, n_cross_sum;
    logic [CNT_W-1:0]   r_pair_count, n_pair_count;
    logic               r_out_valid, n_out_valid;
    logic [THR_W-1:0]   r_thr;

    // datapath
    logic [CW-1:0]      r_mcand, n_mcand;
    logic [MW-1:0]      r_mplier, n_mplier;
    logic [CW-1:0]      r_acc, n_acc;
    logic [P_W-1:0]     r_prod_lr, n_prod_lr;
    logic [P_W+1:0]     r_dot_sq4, n_dot_sq4;
    logic [DIST_W-1:0]  r_dist, n_dist;
    logic [DIST_W-1:0]  r_cand, n_cand;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [DIST_W-1:0]  r_out_dist, n_out_dist;
    logic               r_out_within, n_out_within;

    logic                    w_in_acc;
    logic [2*BYTE_W-1:0]     w_l_sq, w_r_sq, w_lr;
    logic [CW+DIGIT_W-1:0]   w_partial;
    logic                    w_mul_done;
    logic [DIST_W-1:0]       w_try;
    logic [Q_W-1:0]          w_q;
    logic [CW-1:0]           w_rhs;

    // byte products and shared multiplier step
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_l_sq     = i_left_byte * i_left_byte;
    assign w_r_sq     = i_right_byte * i_right_byte;
    assign w_lr       = i_left_byte * i_right_byte;
    assign w_partial  = r_mcand * r_mplier[DIGIT_W-1:0];
    assign w_mul_done = (r_mplier == '0);
    assign w_try      = r_dist | (DIST_W'(1) << r_bit);
    assign w_q        = TWO_Q32 - r_acc[Q_W-1:0];
    assign w_rhs      = CW'({r_dot_sq4, {SHIFT_W{1'b0}}});

    // sequencer and datapath next values
    always_comb begin
        n_state      = r_state;
        n_left_sum   = r_left_sum;
        n_right_sum  = r_right_sum;
        n_cross_sum  = r_cross_sum;
        n_pair_count = r_pair_count;
        n_out_valid  = r_out_valid && i_out_stall;
        n_mcand      = r_mcand;
        n_mplier     = r_mplier;
        n_acc        = r_acc;
        n_prod_lr    = r_prod_lr;
        n_dot_sq4    = r_dot_sq4;
        n_dist       = r_dist;
        n_cand       = r_cand;
        n_bit        = r_bit;
        n_out_dist   = r_out_dist;
        n_out_within = r_out_within;

        // one multiplier digit per cycle in every multiply state
        if (!w_mul_done) begin
            n_acc    = r_acc + w_partial[CW-1:0];
            n_mcand  = r_mcand << DIGIT_W;
            n_mplier = r_mplier >> DIGIT_W;
        end

        case (r_state)
            S_ACC: begin
                if (w_in_acc) begin
                    if (r_pair_count < CNT_W'(MAX_LENGTH)) begin
                        n_left_sum   = r_left_sum + SUM_W'(w_l_sq);
                        n_right_sum  = r_right_sum + SUM_W'(w_r_sq);
                        n_cross_sum  = r_cross_sum + SUM_W'(w_lr);
                        n_pair_count = r_pair_count + 1'b1;
                    end
                    if (i_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (r_left_sum == '0 || r_right_sum == '0) begin
                    n_dist  = (r_left_sum == '0 && r_right_sum == '0) ? '0 : ONE_Q16;
                    n_state = S_OUT;
                end else begin
                    n_mcand  = CW'(r_left_sum);
                    n_mplier = MW'(r_right_sum);
                    n_acc    = '0;
                    n_state  = S_MUL_LR;
                end
            end
            S_MUL_LR: begin
                if (w_mul_done) begin
                    n_prod_lr = r_acc[P_W-1:0];
                    n_mcand   = CW'(r_cross_sum);
                    n_mplier  = MW'(r_cross_sum);
                    n_acc     = '0;
                    n_state   = S_MUL_DD;
                end
            end
            S_MUL_DD: begin
                if (w_mul_done) begin
                    n_dot_sq4 = {r_acc[P_W-1:0], 2'b00};
                    n_dist    = '0;
                    n_bit     = TOP_BIT;
                    n_state   = S_TRY;
                end
            end
            S_TRY: begin
                n_cand = w_try;
                if (w_try <= MAX_DIST) begin
                    n_mcand  = CW'(w_try);
                    n_mplier = MW'(w_try);
                    n_acc    = '0;
                    n_state  = S_MUL_D;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_MUL_D: begin
                if (w_mul_done) begin
                    n_mcand  = CW'(w_q);
                    n_mplier = MW'(w_q);
                    n_acc    = '0;
                    n_state  = S_MUL_Q;
                end
            end
            S_MUL_Q: begin
                if (w_mul_done) begin
                    n_mcand  = r_acc;
                    n_mplier = MW'(r_prod_lr);
                    n_acc    = '0;
                    n_state  = S_MUL_P;
                end
            end
            S_MUL_P: begin
                if (w_mul_done) begin
                    if (r_acc >= w_rhs) begin
                        n_dist = r_cand;
                    end
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_bit == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = S_TRY;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_dist   = r_dist;
                    n_out_within = (r_thr != '0) && (r_dist <= r_thr);
                    n_out_valid  = 1'b1;
                    n_left_sum   = '0;
                    n_right_sum  = '0;
                    n_cross_sum  = '0;
                    n_pair_count = '0;
                    n_state      = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_ACC;
            r_left_sum   <= '0;
            r_right_sum  <= '0;
            r_cross_sum  <= '0;
            r_pair_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_left_sum   <= n_left_sum;
            r_right_sum  <= n_right_sum;
            r_cross_sum  <= n_cross_sum;
            r_pair_count <= n_pair_count;
            r_out_valid  <= n_out_valid;
        end
    end

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_match_threshold;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_mcand      <= n_mcand;
        r_mplier     <= n_mplier;
        r_acc        <= n_acc;
        r_prod_lr    <= n_prod_lr;
        r_dot_sq4    <= n_dot_sq4;
        r_dist       <= n_dist;
        r_cand       <= n_cand;
        r_bit        <= n_bit;
        r_out_dist   <= n_out_dist;
        r_out_within <= n_out_within;
    end

    // ports
    assign o_in_stall         = (r_state != S_ACC);
    assign o_out_valid        = r_out_valid;
    assign o_distance         = r_out_dist;
    assign o_within_threshold = r_out_within;
    assign o_cfg_ready        = 1'b1;

    // checks
    `NLDM_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n,
        r_pair_count <= CNT_W'(MAX_LENGTH), "pair count past limit")
    `NLDM_ASSERT_NEXT(a_acc_open, i_clk, i_rst_n,
        w_in_acc && !i_last, !o_in_stall, "stall after non-last beat")
    `NLDM_ASSERT_IMPL(a_dist_range, i_clk, i_rst_n,
        o_out_valid, o_distance <= MAX_DIST, "distance out of range")

endmodule

/* test/tb_normalized_l2_distance_matcher.sv */
// self-checking testbench for the normalized distance matcher: directed and random fingerprints, own predictor
module tb_normalized_l2_distance_matcher;
    import nldm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PAIRS     = 64;
    localparam int HALF_PERIOD   = 5;
    localparam int MAX_WAIT      = 12;
    localparam int SETTLE_CYCLES = 700;
    localparam int STUCK_LIMIT   = 4000;
    localparam int PHASE_PAIRS   = 70;
    localparam int PHASES        = 7;

    typedef struct {
        logic [BYTE_W-1:0] left_b;
        logic [BYTE_W-1:0] right_b;
        logic              last;
    } t_byte_pair;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              hit;
    } t_match_result;

    typedef enum {
        FP_RANDOM,
        FP_SPARSE,
        FP_SAME,
        FP_SCALED,
        FP_EXTREME,
        FP_LEFT_ZERO,
        FP_RIGHT_ZERO,
        FP_BOTH_ZERO
    } t_fp_style;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [BYTE_W-1:0]  left_byte = '0;
    logic [BYTE_W-1:0]  right_byte = '0;
    logic               last_pair = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DIST_W-1:0]  distance;
    logic               within_threshold;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [THR_W-1:0]   cfg_threshold = '0;

    // pending byte pairs and expected results
    t_byte_pair         pair_q[$];
    t_match_result      result_q[$];

    // predictor state
    logic [31:0]        left_energy = '0;
    logic [31:0]        right_energy = '0;
    logic [31:0]        cross_energy = '0;
    int                 pairs_summed = 0;
    logic [THR_W-1:0]   match_limit = '0;

    int                 fail_count = 0;
    int                 send_wait = 0;
    bit                 send_calm = 1'b0;
    int                 recv_wait = 0;
    bit                 recv_calm = 1'b0;
    int                 stuck_cycles = 0;
    t_byte_pair         cur_pair = '{default: '0};

    normalized_l2_distance_matcher #(
        .MAX_LENGTH(MAX_PAIRS)
    ) u_top (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .o_in_stall            (in_stall),
        .i_left_byte           (left_byte),
        .i_right_byte          (right_byte),
        .i_last                (last_pair),
        .o_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .o_distance            (distance),
        .o_within_threshold    (within_threshold),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (cfg_ready),
        .i_cfg_match_threshold (cfg_threshold)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // largest d in Q1.16 with (2^33 - d^2)^2 * L * R >= 2^66 * dot^2
    function automatic logic [DIST_W-1:0] unit_distance(input logic [31:0] l_sq,
                                                         input logic [31:0] r_sq,
                                                         input logic [31:0] dot);
        logic [127:0]      prod_lr;
        logic [127:0]      dot_term;
        logic [127:0]      q;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] trial;
        if (l_sq == 0 && r_sq == 0)
            return '0;
        if (l_sq == 0 || r_sq == 0)
            return ONE_Q16;
        prod_lr  = 128'(l_sq) * 128'(r_sq);
        dot_term = (128'(dot) * 128'(dot)) << 66;
        d = '0;
        for (int b = DIST_W - 1; b >= 0; b--) begin
            trial = d;
            trial[b] = 1'b1;
            if (trial <= MAX_DIST) begin
                q = (128'(1) << 33) - 128'(trial) * 128'(trial);
                if (q * q * prod_lr >= dot_term)
                    d = trial;
            end
        end
        return d;
    endfunction

    // sum one accepted pair, close the fingerprint on a last beat
    task automatic sum_pair(input t_byte_pair p);
        t_match_result res;
        if (pairs_summed < MAX_PAIRS) begin
            left_energy  += p.left_b * p.left_b;
            right_energy += p.right_b * p.right_b;
            cross_energy += p.left_b * p.right_b;
            pairs_summed++;
        end
        if (p.last) begin
            res.distance = unit_distance(left_energy, right_energy, cross_energy);
            res.hit      = (match_limit != 0) && (res.distance <= match_limit);
            result_q.push_back(res);
            left_energy  = '0;
            right_energy = '0;
            cross_energy = '0;
            pairs_summed = 0;
        end
    endtask

    task automatic push_pair(input int l, input int r, input bit last);
        t_byte_pair p;
        p.left_b  = BYTE_W'(l);
        p.right_b = BYTE_W'(r);
        p.last    = last;
        pair_q.push_back(p);
    endtask

    task automatic push_fingerprint(input int len, input t_fp_style style);
        t_byte_pair p;
        for (int k = 0; k < len; k++) begin
            p.left_b  = BYTE_W'($urandom);
            p.right_b = BYTE_W'($urandom);
            case (style)
                FP_SPARSE: begin
                    if ($urandom_range(0, 2) != 0) p.left_b = '0;
                    if ($urandom_range(0, 2) != 0) p.right_b = '0;
                end
                FP_SAME:       p.right_b = p.left_b;
                FP_SCALED:     p.right_b = p.left_b >> 1;
                FP_EXTREME: begin
                    p.left_b  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    p.right_b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                FP_LEFT_ZERO:  p.left_b = '0;
                FP_RIGHT_ZERO: p.right_b = '0;
                FP_BOTH_ZERO: begin
                    p.left_b  = '0;
                    p.right_b = '0;
                end
                default: ;
            endcase
            p.last = (k == len - 1);
            pair_q.push_back(p);
        end
    endtask

    // hold off until every pair is sent and every result is back, then let the block settle
    task automatic wait_drained;
        do @(posedge clk);
        while (pair_q.size() != 0 || in_valid || result_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(posedge clk);
        cfg_valid     <= 1'b1;
        cfg_threshold <= value;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        match_limit = value;
    endtask

    // pair driver: one beat per queued pair, random gaps between beats
    always @(posedge clk) begin
        logic accepted;
        logic next_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            accepted = in_valid && !in_stall;
            if (accepted)
                sum_pair(cur_pair);
            next_valid = in_valid && !accepted;
            if (!next_valid) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pair_q.size() != 0) begin
                    cur_pair   = pair_q.pop_front();
                    next_valid = 1'b1;
                    if ($urandom_range(0, 29) == 0)
                        send_calm = !send_calm;
                    send_wait = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
                end
            end
            in_valid   <= next_valid;
            left_byte  <= cur_pair.left_b;
            right_byte <= cur_pair.right_b;
            last_pair  <= cur_pair.last;
        end
    end

    // result monitor: each beat waits out a drawn number of stalled cycles
    always @(posedge clk) begin
        t_match_result exp_res;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected: distance %0d", distance);
                    fail_count++;
                end else begin
                    exp_res = result_q.pop_front();
                    if (distance !== exp_res.distance) begin
                        $error("distance mismatch: expected %0d, actual %0d",
                               exp_res.distance, distance);
                        fail_count++;
                    end
                    if (within_threshold !== exp_res.hit) begin
                        $error("within_threshold mismatch: expected %0d, actual %0d",
                               exp_res.hit, within_threshold);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 9) == 0)
                    recv_calm = !recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (out_valid && recv_wait > 0) begin
                recv_wait--;
            end
            out_stall <= (recv_wait > 0);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus: reset, directed fingerprints, then random phases with new thresholds
    initial begin
        logic [THR_W-1:0] phase_thr[PHASES];
        int               items_left;
        int               len;
        int               pick;
        t_fp_style        style;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // threshold of one so that a single zero vector lands exactly on it
        write_threshold(ONE_Q16);
        push_pair(0, 0, 1);
        push_pair(255, 0, 1);
        push_pair(0, 255, 1);
        push_pair(255, 255, 1);
        push_pair(255, 0, 0);
        push_pair(0, 255, 1);
        push_pair(1, 255, 0);
        push_pair(255, 1, 1);
        push_pair(200, 100, 0);
        push_pair(100, 200, 1);
        push_pair(0, 0, 0);
        push_pair(0, 0, 0);
        push_pair(7, 0, 1);
        push_pair(128, 127, 0);
        push_pair(127, 128, 1);
        // overflow: the left side stays zero over the counted pairs, later bytes must be ignored
        for (int k = 0; k < MAX_PAIRS; k++)
            push_pair(0, $urandom_range(1, 255), 0);
        push_pair(255, 0, 0);
        push_pair(255, 255, 1);
        wait_drained();

        phase_thr[0] = '0;
        phase_thr[1] = '1;
        phase_thr[2] = THR_W'(1);
        phase_thr[3] = MAX_DIST;
        phase_thr[4] = THR_W'($urandom_range(0, 131071));
        phase_thr[5] = THR_W'($urandom_range(30000, 70000));
        phase_thr[6] = THR_W'($urandom_range(1, 20000));

        for (int ph = 0; ph < PHASES; ph++) begin
            write_threshold(phase_thr[ph]);
            items_left = PHASE_PAIRS;
            while (items_left > 0) begin
                // mostly short fingerprints, some longer up to full length and a few overlong ones
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    len = $urandom_range(1, 8);
                else if (pick < 92)
                    len = $urandom_range(9, MAX_PAIRS);
                else
                    len = $urandom_range(MAX_PAIRS + 1, MAX_PAIRS + 8);
                pick = $urandom_range(0, 19);
                if (pick < 8)
                    style = FP_RANDOM;
                else if (pick < 11)
                    style = FP_SPARSE;
                else if (pick < 13)
                    style = FP_SAME;
                else if (pick < 15)
                    style = FP_SCALED;
                else if (pick < 17)
                    style = FP_EXTREME;
                else if (pick < 18)
                    style = FP_LEFT_ZERO;
                else if (pick < 19)
                    style = FP_RIGHT_ZERO;
                else
                    style = FP_BOTH_ZERO;
                push_fingerprint(len, style);
                items_left -= len;
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
